>>> rtl/alusf_pkg.sv
`default_nettype none

package alusf_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned OpW   = 5;
  localparam int unsigned FlagW = 5;
  localparam int unsigned Digits = WordW / 4;

  localparam logic [4:0] DigitMax  = 5'd9;
  localparam logic [4:0] DigitBase = 5'd10;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 5'd0,
    OP_ADDC  = 5'd1,
    OP_SUB   = 5'd2,
    OP_SUBC  = 5'd3,
    OP_DADD  = 5'd4,
    OP_CMP   = 5'd5,
    OP_XOR   = 5'd6,
    OP_AND   = 5'd7,
    OP_OR    = 5'd8,
    OP_BIT   = 5'd9,
    OP_BIC   = 5'd10,
    OP_BIS   = 5'd11,
    OP_MOV   = 5'd12,
    OP_SWPB  = 5'd13,
    OP_SRA   = 5'd14,
    OP_RRC   = 5'd15,
    OP_SXT   = 5'd16,
    OP_SETCC = 5'd17,
    OP_CLRCC = 5'd18,
    OP_MOVL  = 5'd19,
    OP_MOVLZ = 5'd20,
    OP_MOVLS = 5'd21,
    OP_MOVH  = 5'd22
  } op_e;

  // Same bit layout as flag_mask: {overflow, sleep, negative, zero, carry}
  typedef struct packed {
    logic v;
    logic s;
    logic n;
    logic z;
    logic c;
  } status_t;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic             byte_mode;
    logic [WordW-1:0] source_value;
    logic [WordW-1:0] destination_value;
    logic [FlagW-1:0] flag_mask;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] result_value;
    logic             write_back;
    logic             fault;
    logic             carry_out;
    logic             zero_out;
    logic             negative_out;
    logic             overflow_out;
    logic             sleep_out;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/alusf_in_if.sv
`default_nettype none

interface alusf_in_if;
  import alusf_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

>>> rtl/alusf_out_if.sv
`default_nettype none

interface alusf_out_if;
  import alusf_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

>>> rtl/alu_with_status_flags.sv
`default_nettype none

// Channel  | Dir | Interface     | Beat
// ---------+-----+---------------+----------------------------------------------
// in_i     | in  | alusf_in_if   | operation, byte_mode, source, dest, flag mask
// res_o    | out | alusf_out_if  | result, write_back, fault, five status flags
//
// One beat per cycle while res_o is not stalled: a beat is held in the input register, then the ALU
// and flag update run in a single combinational pass into the result register.
// Reset clears both valid stages and the status word.
// A stalled res_o holds the result; in_i keeps taking a beat while the input
// stage can move on or is empty.

module alu_with_status_flags
  import alusf_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  alusf_in_if.sink      in_i,
  alusf_out_if.source   res_o
);

  in_item_t  in_q;
  logic      in_v_q;
  out_item_t out_q, out_d;
  logic      out_v_q;
  status_t   status_q, status_d;

  logic out_free;
  logic in_adv;

  assign out_free   = !out_v_q || res_o.ready;
  assign in_adv     = in_v_q && out_free;
  assign in_i.ready = !in_v_q || out_free;

  assign res_o.valid = out_v_q;
  assign res_o.item  = out_q;

  function automatic logic low_zero(logic [WordW-1:0] v, logic bm);
    return bm ? (v[ByteW-1:0] == '0) : (v == '0);
  endfunction

  function automatic logic low_msb(logic [WordW-1:0] v, logic bm);
    return bm ? v[ByteW-1] : v[WordW-1];
  endfunction

  always_comb begin
    logic [WordW-1:0] s, d, sx, res, acc, bit_sel, r;
    logic             bm, c, cin, cy, cy_byte, wb, flt;
    logic [WordW:0]   sum_w;
    logic [ByteW:0]   sum_b;
    logic             ms, md, mr;
    logic [4:0]       t;
    status_t          st;

    s       = in_q.source_value;
    d       = in_q.destination_value;
    bm      = in_q.byte_mode;
    c       = status_q.c;
    st      = status_q;
    res     = d;
    wb      = 1'b0;
    flt     = 1'b0;
    sx      = s;
    cin     = 1'b0;
    acc     = '0;
    cy      = c;
    cy_byte = c;
    t       = '0;
    r       = '0;
    bit_sel = '0;

    // Shared adder for add, addc, sub, subc, cmp
    if (in_q.operation == OP_SUB || in_q.operation == OP_CMP ||
        in_q.operation == OP_SUBC) begin
      sx = ~s;
    end
    if (in_q.operation == OP_ADDC || in_q.operation == OP_SUBC) begin
      cin = c;
    end else if (in_q.operation == OP_SUB || in_q.operation == OP_CMP) begin
      cin = 1'b1;
    end
    sum_w = {1'b0, sx} + {1'b0, d} + {{WordW{1'b0}}, cin};
    sum_b = {1'b0, sx[ByteW-1:0]} + {1'b0, d[ByteW-1:0]} + {{ByteW{1'b0}}, cin};
    ms    = low_msb(sx, bm);
    md    = low_msb(d, bm);
    mr    = bm ? sum_b[ByteW-1] : sum_w[WordW-1];

    // Decimal digit chain; byte mode takes the carry out of the second digit
    for (int i = 0; i < Digits; i++) begin
      t  = {1'b0, s[4*i +: 4]} + {1'b0, d[4*i +: 4]} + {4'b0, cy};
      cy = (t > DigitMax);
      if (cy) begin
        t = t - DigitBase;
      end
      acc[4*i +: 4] = t[3:0];
      if (i == 1) begin
        cy_byte = cy;
      end
    end

    bit_sel = WordW'(1) << s[3:0];

    unique case (in_q.operation)
      OP_ADD, OP_ADDC, OP_SUB, OP_SUBC, OP_CMP: begin
        res  = bm ? {d[WordW-1:ByteW], sum_b[ByteW-1:0]} : sum_w[WordW-1:0];
        st.c = bm ? sum_b[ByteW] : sum_w[WordW];
        st.z = low_zero(res, bm);
        st.n = mr;
        st.v = (ms == md) && (ms != mr);
        if (in_q.operation == OP_CMP) begin
          res = d;
        end else begin
          wb = 1'b1;
        end
      end
      OP_DADD: begin
        res  = bm ? {d[WordW-1:ByteW], acc[ByteW-1:0]} : acc;
        wb   = 1'b1;
        st.c = bm ? cy_byte : cy;
        st.z = low_zero(acc, bm);
        st.n = 1'b0;
        st.v = 1'b0;
      end
      OP_XOR, OP_AND, OP_OR, OP_MOV: begin
        if (in_q.operation == OP_XOR)      r = d ^ s;
        else if (in_q.operation == OP_AND) r = d & s;
        else if (in_q.operation == OP_OR)  r = d | s;
        else                               r = s;
        res = bm ? {d[WordW-1:ByteW], r[ByteW-1:0]} : r;
        wb  = 1'b1;
        if (in_q.operation != OP_MOV) begin
          st.z = low_zero(res, bm);
          st.n = low_msb(res, bm);
        end
      end
      OP_BIT, OP_BIC, OP_BIS: begin
        flt = bm ? (s[ByteW-1:3] != '0) : (s[WordW-1:4] != '0);
        if (!flt) begin
          if (in_q.operation == OP_BIT) begin
            st.z = ((d & bit_sel) == '0);
          end else begin
            res  = (in_q.operation == OP_BIC) ? (d & ~bit_sel) : (d | bit_sel);
            wb   = 1'b1;
            st.z = low_zero(res, bm);
            st.n = low_msb(res, bm);
          end
        end
      end
      OP_SWPB: begin
        res = {d[ByteW-1:0], d[WordW-1:ByteW]};
        wb  = 1'b1;
      end
      OP_SRA, OP_RRC: begin
        // Shift in the old sign for sra, the old carry for rrc
        if (bm) begin
          res = {d[WordW-1:ByteW],
                 (in_q.operation == OP_SRA) ? d[ByteW-1] : c, d[ByteW-1:1]};
        end else begin
          res = {(in_q.operation == OP_SRA) ? d[WordW-1] : c, d[WordW-1:1]};
        end
        wb   = 1'b1;
        st.z = low_zero(res, bm);
        st.n = low_msb(res, bm);
        if (in_q.operation == OP_RRC) begin
          st.c = d[0];
        end
      end
      OP_SXT: begin
        res  = {{(WordW-ByteW){d[ByteW-1]}}, d[ByteW-1:0]};
        wb   = 1'b1;
        st.z = (res == '0);
        st.n = d[ByteW-1];
      end
      OP_SETCC: st = status_t'(status_q | in_q.flag_mask);
      OP_CLRCC: st = status_t'(status_q & ~in_q.flag_mask);
      OP_MOVL: begin
        res = {d[WordW-1:ByteW], s[ByteW-1:0]};
        wb  = 1'b1;
      end
      OP_MOVLZ: begin
        res = {{(WordW-ByteW){1'b0}}, s[ByteW-1:0]};
        wb  = 1'b1;
      end
      OP_MOVLS: begin
        res = {{(WordW-ByteW){1'b1}}, s[ByteW-1:0]};
        wb  = 1'b1;
      end
      OP_MOVH: begin
        res = {s[ByteW-1:0], d[ByteW-1:0]};
        wb  = 1'b1;
      end
      default: begin
        // Unused codes: no write, status kept
        res = d;
      end
    endcase

    status_d           = st;
    out_d.result_value = res;
    out_d.write_back   = wb;
    out_d.fault        = flt;
    out_d.carry_out    = st.c;
    out_d.zero_out     = st.z;
    out_d.negative_out = st.n;
    out_d.overflow_out = st.v;
    out_d.sleep_out    = st.s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      status_q <= '0;
    end else begin
      if (in_i.ready) begin
        in_v_q <= in_i.valid;
      end
      if (out_free) begin
        out_v_q <= in_v_q;
      end
      if (in_adv) begin
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.item;
    end
    if (in_adv) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_alu_with_status_flags.sv
`timescale 1ns / 100ps

module tb_alu_with_status_flags;
  import alusf_pkg::*;

  localparam logic [OpW-1:0] OpUnusedLo = 5'd23;
  localparam logic [OpW-1:0] OpUnusedHi = 5'd31;
  localparam int unsigned    LongHold   = 300;
  localparam int unsigned    DrainLimit = 5000;
  localparam int unsigned    TailWait   = 10;

  localparam logic [WordW-1:0] Corners [8] = '{
    16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h00FF, 16'h0080, 16'h007F, 16'hFF00
  };

  typedef struct {
    in_item_t  beat;
    bit        known;
    out_item_t want;
  } alu_row_t;

  logic clk;
  logic rst_n;

  alusf_in_if  in_if ();
  alusf_out_if res_if ();

  alu_with_status_flags u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  status_t    status_model;
  out_item_t  pending_results [$];
  alu_row_t   dir_rows [$];
  int unsigned mismatches;
  int unsigned beats_issued;
  int unsigned results_checked;
  int unsigned faults_seen;
  int unsigned writes_seen;
  bit          sink_hold_req;
  bit          quiet_tail;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Executes one instruction on the flag model and returns the result beat.
  function automatic out_item_t exec_alu(input in_item_t beat, inout status_t st);
    int unsigned s, d, wm, msb, keep, res, sx, dl, cin, sum, r, idx, acc, cy, t, bitv;
    int unsigned digits;
    logic        wb, flt;
    out_item_t   o;
    s    = beat.source_value;
    d    = beat.destination_value;
    wm   = beat.byte_mode ? 32'h00FF : 32'hFFFF;
    msb  = beat.byte_mode ? 32'h0080 : 32'h8000;
    keep = d & ~wm & 32'hFFFF;
    res  = d;
    wb   = 1'b0;
    flt  = 1'b0;
    case (beat.operation)
      OP_ADD, OP_ADDC, OP_SUB, OP_SUBC, OP_CMP: begin
        sx  = s;
        cin = 0;
        if (beat.operation == OP_ADDC) cin = st.c;
        if (beat.operation == OP_SUB || beat.operation == OP_CMP) begin
          sx  = ~s;
          cin = 1;
        end
        if (beat.operation == OP_SUBC) begin
          sx  = ~s;
          cin = st.c;
        end
        sx   = sx & wm;
        dl   = d & wm;
        sum  = sx + dl + cin;
        r    = sum & wm;
        st.c = sum > wm;
        st.z = r == 0;
        st.n = (r & msb) != 0;
        st.v = ((~(sx ^ dl)) & (sx ^ r) & msb) != 0;
        if (beat.operation != OP_CMP) begin
          res = keep | r;
          wb  = 1'b1;
        end
      end
      OP_DADD: begin
        digits = beat.byte_mode ? 2 : 4;
        acc    = 0;
        cy     = st.c;
        for (int i = 0; i < digits; i++) begin
          t = ((s >> (4 * i)) & 32'hF) + ((d >> (4 * i)) & 32'hF) + cy;
          if (t > DigitMax) begin
            t  = t - DigitBase;
            cy = 1;
          end else begin
            cy = 0;
          end
          // cut each digit to four bits
          acc = acc | ((t & 32'hF) << (4 * i));
        end
        st.c = cy != 0;
        st.z = acc == 0;
        st.n = 1'b0;
        st.v = 1'b0;
        res  = keep | acc;
        wb   = 1'b1;
      end
      OP_XOR, OP_AND, OP_OR: begin
        if (beat.operation == OP_XOR)      r = (d ^ s) & wm;
        else if (beat.operation == OP_AND) r = (d & s) & wm;
        else                               r = (d | s) & wm;
        res  = keep | r;
        wb   = 1'b1;
        st.z = r == 0;
        st.n = (r & msb) != 0;
      end
      OP_BIT, OP_BIC, OP_BIS: begin
        idx = s & wm;
        if (idx > (beat.byte_mode ? 7 : 15)) begin
          flt = 1'b1;
        end else begin
          bitv = 1 << idx;
          if (beat.operation == OP_BIT) begin
            st.z = (d & bitv) == 0;
          end else begin
            res  = (beat.operation == OP_BIC) ? (d & ~bitv & 32'hFFFF) : (d | bitv);
            wb   = 1'b1;
            st.z = (res & wm) == 0;
            st.n = (res & msb) != 0;
          end
        end
      end
      OP_MOV: begin
        res = keep | (s & wm);
        wb  = 1'b1;
      end
      OP_SWPB: begin
        res = ((d & 32'h00FF) << 8) | ((d >> 8) & 32'h00FF);
        wb  = 1'b1;
      end
      OP_SRA: begin
        dl   = d & wm;
        r    = (dl >> 1) | (dl & msb);
        res  = keep | r;
        wb   = 1'b1;
        st.z = r == 0;
        st.n = (r & msb) != 0;
      end
      OP_RRC: begin
        dl   = d & wm;
        r    = (dl >> 1) | (st.c ? msb : 0);
        res  = keep | r;
        wb   = 1'b1;
        st.c = d[0];
        st.z = r == 0;
        st.n = (r & msb) != 0;
      end
      OP_SXT: begin
        res  = (d & 32'h0080) != 0 ? (d | 32'hFF00) : (d & 32'h00FF);
        wb   = 1'b1;
        st.z = (res & 32'hFFFF) == 0;
        st.n = (res & 32'h8000) != 0;
      end
      OP_SETCC: st = status_t'(st | beat.flag_mask);
      OP_CLRCC: st = status_t'(st & ~beat.flag_mask);
      OP_MOVL: begin
        res = (d & 32'hFF00) | (s & 32'h00FF);
        wb  = 1'b1;
      end
      OP_MOVLZ: begin
        res = s & 32'h00FF;
        wb  = 1'b1;
      end
      OP_MOVLS: begin
        res = 32'hFF00 | (s & 32'h00FF);
        wb  = 1'b1;
      end
      OP_MOVH: begin
        res = (d & 32'h00FF) | ((s & 32'h00FF) << 8);
        wb  = 1'b1;
      end
      default: ;
    endcase
    o.result_value = res[15:0];
    o.write_back   = wb;
    o.fault        = flt;
    o.carry_out    = st.c;
    o.zero_out     = st.z;
    o.negative_out = st.n;
    o.overflow_out = st.v;
    o.sleep_out    = st.s;
    return o;
  endfunction

  function automatic in_item_t make_beat(logic [OpW-1:0] op, logic bm, logic [WordW-1:0] s,
                                         logic [WordW-1:0] d, logic [FlagW-1:0] m);
    in_item_t b;
    b.operation         = op;
    b.byte_mode         = bm;
    b.source_value      = s;
    b.destination_value = d;
    b.flag_mask         = m;
    return b;
  endfunction

  task automatic add_row(logic [OpW-1:0] op, logic bm, logic [WordW-1:0] s,
                         logic [WordW-1:0] d, logic [FlagW-1:0] m);
    alu_row_t row;
    row.beat  = make_beat(op, bm, s, d, m);
    row.known = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endtask

  // flags are given as {overflow, sleep, negative, zero, carry}
  task automatic add_known_row(logic [OpW-1:0] op, logic bm, logic [WordW-1:0] s,
                               logic [WordW-1:0] d, logic [FlagW-1:0] m,
                               logic [WordW-1:0] res, logic wb, logic flt, status_t fl);
    alu_row_t row;
    row.beat               = make_beat(op, bm, s, d, m);
    row.known              = 1'b1;
    row.want.result_value  = res;
    row.want.write_back    = wb;
    row.want.fault         = flt;
    row.want.carry_out     = fl.c;
    row.want.zero_out      = fl.z;
    row.want.negative_out  = fl.n;
    row.want.overflow_out  = fl.v;
    row.want.sleep_out     = fl.s;
    dir_rows.push_back(row);
  endtask

  function automatic logic [WordW-1:0] rand_operand();
    if ($urandom_range(0, 3) == 0) return Corners[$urandom_range(0, 7)];
    return WordW'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic in_item_t rand_instr();
    in_item_t b;
    if ($urandom_range(0, 99) < 4) b.operation = OpW'($urandom_range(OpUnusedLo, OpUnusedHi));
    else                           b.operation = OpW'($urandom_range(OP_ADD, OP_MOVH));
    b.byte_mode         = 1'($urandom_range(0, 1));
    b.source_value      = rand_operand();
    b.destination_value = rand_operand();
    b.flag_mask         = FlagW'($urandom_range(0, 31));
    // keep bit indexes mostly near the legal range
    if ((b.operation == OP_BIT || b.operation == OP_BIC || b.operation == OP_BIS) &&
        $urandom_range(0, 3) != 0) begin
      if (b.byte_mode) b.source_value[7:0] = 8'($urandom_range(0, 9));
      else             b.source_value      = WordW'($urandom_range(0, 17));
    end
    return b;
  endfunction

  task automatic issue_beat(in_item_t beat, bit known, out_item_t want);
    out_item_t pred;
    in_if.item  <= beat;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    pred = exec_alu(beat, status_model);
    pending_results.push_back(known ? want : pred);
    beats_issued++;
  endtask

  task automatic idle_in(int unsigned n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic rand_phase(int unsigned n, bit gaps);
    repeat (n) begin
      if (gaps && $urandom_range(0, 5) == 0) idle_in($urandom_range(1, 12));
      issue_beat(rand_instr(), 1'b0, '0);
    end
  endtask

  function automatic void check_field(string name, logic [WordW-1:0] want,
                                      logic [WordW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    out_item_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = res_if.item;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: 0x%0h", got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_value", want.result_value, got.result_value);
        check_field("write_back",   want.write_back,   got.write_back);
        check_field("fault",        want.fault,        got.fault);
        check_field("carry_out",    want.carry_out,    got.carry_out);
        check_field("zero_out",     want.zero_out,     got.zero_out);
        check_field("negative_out", want.negative_out, got.negative_out);
        check_field("overflow_out", want.overflow_out, got.overflow_out);
        check_field("sleep_out",    want.sleep_out,    got.sleep_out);
        results_checked++;
        if (got.fault === 1'b1)      faults_seen++;
        if (got.write_back === 1'b1) writes_seen++;
      end
    end
  end

  // Result sink: random stall bursts, one long hold-off on request, none in the tail.
  initial begin : result_sink
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned guard;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.item   <= '0;
    status_model  = '0;
    mismatches    = 0;
    sink_hold_req = 1'b0;
    quiet_tail    = 1'b0;

    add_known_row(OP_ADD,   1'b0, 16'hFFFF, 16'h0001, 5'h00, 16'h0000, 1'b1, 1'b0, 5'b00011);
    add_known_row(OP_ADDC,  1'b0, 16'h7FFF, 16'h0000, 5'h00, 16'h8000, 1'b1, 1'b0, 5'b10100);
    add_known_row(OP_SUB,   1'b1, 16'h0001, 16'hAB00, 5'h00, 16'hABFF, 1'b1, 1'b0, 5'b00100);
    add_known_row(OP_CMP,   1'b0, 16'h8000, 16'h8000, 5'h00, 16'h8000, 1'b0, 1'b0, 5'b00011);
    add_row(OP_SUBC,  1'b0, 16'h0000, 16'h0000, 5'h00);
    add_row(OP_DADD,  1'b0, 16'h9999, 16'h0001, 5'h00);
    add_row(OP_DADD,  1'b1, 16'h00FF, 16'hFF0F, 5'h00);   // digits above nine
    add_row(OP_XOR,   1'b1, 16'hFFFF, 16'h1234, 5'h00);
    add_row(OP_AND,   1'b1, 16'h0000, 16'hFFFF, 5'h00);
    add_row(OP_OR,    1'b0, 16'h8000, 16'h0001, 5'h00);
    add_known_row(OP_CLRCC, 1'b0, 16'h0000, 16'hFFFF, 5'h1F, 16'hFFFF, 1'b0, 1'b0, 5'b00000);
    add_known_row(OP_BIT,   1'b0, 16'h0010, 16'h5A5A, 5'h00, 16'h5A5A, 1'b0, 1'b1, 5'b00000);
    add_known_row(OP_BIC,   1'b1, 16'h0108, 16'hA5A5, 5'h00, 16'hA5A5, 1'b0, 1'b1, 5'b00000);
    add_known_row(OP_SETCC, 1'b0, 16'hFFFF, 16'h0000, 5'h1F, 16'h0000, 1'b0, 1'b0, 5'b11111);
    add_row(OP_BIT,   1'b0, 16'h000F, 16'h8000, 5'h00);
    add_row(OP_BIC,   1'b0, 16'h000F, 16'hFFFF, 5'h00);
    add_row(OP_BIS,   1'b1, 16'hFF07, 16'h0000, 5'h00);
    add_row(OP_MOV,   1'b1, 16'hABCD, 16'h1200, 5'h00);
    add_row(OP_SWPB,  1'b1, 16'h0000, 16'h12AB, 5'h00);
    add_row(OP_SRA,   1'b0, 16'h0000, 16'h8001, 5'h00);
    add_row(OP_RRC,   1'b1, 16'h0000, 16'h0001, 5'h00);   // byte rotate, zero on whole byte
    add_row(OP_SXT,   1'b1, 16'h0000, 16'h0080, 5'h00);
    add_row(OP_MOVL,  1'b0, 16'hFFFF, 16'h1234, 5'h00);
    add_row(OP_MOVLZ, 1'b1, 16'hFFFF, 16'h1234, 5'h00);
    add_row(OP_MOVLS, 1'b0, 16'h0000, 16'h1234, 5'h00);
    add_row(OP_MOVH,  1'b1, 16'hFFFF, 16'h1234, 5'h00);
    add_row(OpUnusedHi, 1'b1, 16'hFFFF, 16'hFFFF, 5'h1F);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) issue_beat(dir_rows[i].beat, dir_rows[i].known, dir_rows[i].want);

    rand_phase(620, 1'b1);

    // back up the pipeline behind a long sink stall
    sink_hold_req = 1'b1;
    rand_phase(30, 1'b0);

    // hold the source until everything has drained
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);

    rand_phase(620, 1'b1);

    quiet_tail = 1'b1;
    rand_phase(250, 1'b0);
    in_if.valid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < DrainLimit) begin
      @(posedge clk);
      guard++;
    end
    repeat (TailWait) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Issued %0d instructions (%0d directed) with random source and sink stalls.",
             beats_issued, dir_rows.size());
    $display("Checked %0d results: %0d wrote back, %0d raised a bit-index fault.",
             results_checked, writes_seen, faults_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> alu_with_status_flags.f
rtl/alusf_pkg.sv
rtl/alusf_in_if.sv
rtl/alusf_out_if.sv
rtl/alu_with_status_flags.sv
tb/tb_alu_with_status_flags.sv
